[rtl/core/pfr_pkg.sv]
// pfr_pkg: shared types and constants for the pwm frequency ramp block
// no dependencies
package pfr_pkg;
   localparam int FREQ_BITS = 20;
   localparam logic [15:0] TIMER_MAX = 16'hFFFF;
   localparam logic [31:0] CLK_RESET = 32'd72000000;
   localparam logic [9:0] PERIOD_RESET = 10'd10;
   localparam logic [0:0] REG_CLK = 1'b0;
   localparam logic [0:0] REG_PERIOD = 1'b1;

   typedef struct packed {
      logic enable;
      logic [FREQ_BITS-1:0] target_freq;
      logic [15:0] ramp_time_ms;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic pwm_on;
      logic [FREQ_BITS-1:0] current_freq;
      logic [15:0] prescaler;
      logic [15:0] reload;
      logic [15:0] compare;
      logic reprogrammed;
   } rsp_type;

   // divider operations
   localparam logic [1:0] DIV_STEPS = 2'd0;
   localparam logic [1:0] DIV_STEP = 2'd1;
   localparam logic [1:0] DIV_PRESC = 2'd2;
   localparam logic [1:0] DIV_RELOAD = 2'd3;

   // controller commands to the datapath
   typedef struct packed {
      logic load;       // latch request
      logic div_start;
      logic [1:0] div_op;
      logic decide;     // evaluate ramp decision
      logic prog_start; // begin timer programming
      logic finish;     // build result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_prog;  // decision asks for timer programming
      logic presc_fit;  // prescaler within range
   } sts_type;
endpackage

[rtl/core/pfr_if.sv]
// pfr_if: valid/ready channel carrying one payload
// depends on pfr_pkg
interface pfr_req_if;
   import pfr_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface pfr_rsp_if;
   import pfr_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/pfr_div.sv]
// pfr_div: 64 by 64 bit restoring divider, one quotient bit per cycle
// depends on pfr_pkg
module pfr_div
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   logic [63:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[63]};
      if (start) begin
         quo_in = dividend; rem_in = '0; den_in = divisor;
         cnt_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 64'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/core/pfr_datapath.sv]
// pfr_datapath: ramp state, step arithmetic and timer settings
// depends on pfr_pkg, pfr_div
module pfr_datapath
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  req_type     req,
   input  logic [31:0] clk_hz,
   input  logic [9:0]  period_ms,
   output rsp_type     result
);
   req_type r_ff;
   logic [FREQ_BITS-1:0] freq_ff, freq_in, pfreq_ff, pfreq_in;
   logic run_ff, run_in, touch_ff, touch_in, prog_ff, prog_in;
   logic [31:0] last_ff, last_in;
   logic [15:0] presc_ff, presc_in, rel_ff, rel_in;
   logic [15:0] steps_ff, steps_in;
   logic [FREQ_BITS:0] step_ff, step_in;
   logic [16:0] pval_ff, pval_in;
   logic [15:0] per;
   logic [63:0] dvd, dvs, quo;
   logic [FREQ_BITS-1:0] tgt, base;
   logic [FREQ_BITS:0] nxt;
   logic [31:0] fr;
   logic ddone;

   pfr_div u_div (.clock, .reset, .start(cmd.div_start), .dividend(dvd),
      .divisor(dvs), .done(ddone), .quotient(quo));

   assign per = (period_ms == '0) ? 16'd1 : {6'd0, period_ms};
   assign tgt = r_ff.enable ? r_ff.target_freq : '0;
   assign base = r_ff.enable ? ((r_ff.target_freq == '0) ? FREQ_BITS'(1) : r_ff.target_freq)
                             : freq_ff;
   assign fr = (pfreq_ff == '0) ? 32'd1 : 32'(pfreq_ff);

   always_comb begin
      dvd = '0; dvs = 64'd1;
      case (cmd.div_op)
         DIV_STEPS: begin dvd = 64'(r_ff.ramp_time_ms); dvs = 64'(per); end
         DIV_STEP: begin
            dvd = 64'(base) + 64'(steps_ff) - 64'd1; dvs = 64'(steps_ff);
         end
         DIV_PRESC: begin dvd = 64'(clk_hz); dvs = 64'(fr) * 64'd65537; end
         DIV_RELOAD: begin dvd = 64'(clk_hz); dvs = 64'(49'(pval_ff) * 49'(fr)); end
         default: ;
      endcase
   end

   always_comb begin
      freq_in = freq_ff; run_in = run_ff; last_in = last_ff; touch_in = touch_ff;
      presc_in = presc_ff; rel_in = rel_ff; pfreq_in = pfreq_ff; prog_in = prog_ff;
      steps_in = steps_ff; step_in = step_ff; pval_in = pval_ff;
      nxt = (FREQ_BITS+1)'(freq_ff) + step_ff;
      if (cmd.load) begin
         touch_in = 1'b0; prog_in = 1'b0;
      end
      if (ddone) begin
         case (cmd.div_op)
            DIV_STEPS: steps_in = (quo == '0) ? 16'd1 : quo[15:0];
            DIV_STEP: step_in = (quo == '0) ? (FREQ_BITS+1)'(1) : quo[FREQ_BITS:0];
            DIV_PRESC: pval_in = (quo > 64'(TIMER_MAX)) ? 17'h1FFFF : 17'(quo) + 17'd1;
            DIV_RELOAD: begin
               if (quo != '0 && quo <= 64'h10000) begin
                  presc_in = 16'(pval_ff - 17'd1);
                  rel_in = 16'(quo - 64'd1);
               end
            end
            default: ;
         endcase
      end
      if (cmd.decide) begin
         if (r_ff.ramp_time_ms == '0) begin
            freq_in = tgt;
            if (tgt == '0) run_in = 1'b0;
            else begin run_in = 1'b1; prog_in = 1'b1; pfreq_in = tgt; end
         end else if ((r_ff.now_ms - last_ff) >= 32'(per)) begin
            last_in = r_ff.now_ms;
            if (freq_ff < tgt) begin
               if (freq_ff == '0) begin
                  run_in = 1'b1; freq_in = FREQ_BITS'(1);
                  pfreq_in = FREQ_BITS'(1); prog_in = 1'b1;
               end else begin
                  freq_in = (nxt > (FREQ_BITS+1)'(tgt)) ? tgt : nxt[FREQ_BITS-1:0];
                  pfreq_in = freq_in; prog_in = 1'b1;
               end
            end else if (freq_ff > tgt) begin
               if ((FREQ_BITS+1)'(freq_ff) <= step_ff) begin
                  freq_in = '0; run_in = 1'b0;
               end else begin
                  freq_in = FREQ_BITS'((FREQ_BITS+1)'(freq_ff) - step_ff);
                  pfreq_in = freq_in; prog_in = 1'b1;
               end
            end else if (freq_ff == '0) run_in = 1'b0;
         end
      end
      if (cmd.prog_start) begin
         touch_in = 1'b1; presc_in = TIMER_MAX; rel_in = TIMER_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) r_ff <= req;
      steps_ff <= steps_in; step_ff <= step_in; pval_ff <= pval_in;
      pfreq_ff <= pfreq_in;
      // finish can coincide with the last divider result, so take next values
      if (cmd.finish) begin
         result.pwm_on <= run_in;
         result.current_freq <= freq_in;
         result.prescaler <= presc_in;
         result.reload <= rel_in;
         result.compare <= 16'((17'(rel_in) + 17'd1) >> 1);
         result.reprogrammed <= touch_in;
      end
      if (reset) begin
         freq_ff <= '0; run_ff <= 1'b0; last_ff <= '0; presc_ff <= '0; rel_ff <= '0;
         touch_ff <= 1'b0; prog_ff <= 1'b0;
      end else begin
         freq_ff <= freq_in; run_ff <= run_in; last_ff <= last_in; presc_ff <= presc_in;
         rel_ff <= rel_in; touch_ff <= touch_in; prog_ff <= prog_in;
      end
   end

   assign sts.div_done = ddone;
   assign sts.need_prog = prog_ff;
   assign sts.presc_fit = (pval_ff != 17'h1FFFF);
endmodule

[rtl/core/pfr_ctrl.sv]
// pfr_ctrl: sequencer for one update, drives divider steps and handshakes
// depends on pfr_pkg
module pfr_ctrl
   import pfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   input  sts_type sts
);
   localparam logic [2:0] S_IDLE = 3'd0, S_STEPS = 3'd1, S_STEP = 3'd2,
      S_DECIDE = 3'd3, S_PRESC = 3'd4, S_RELOAD = 3'd5, S_FINISH = 3'd6, S_OUT = 3'd7;
   logic [2:0] st_ff, st_in;
   logic kick_ff, kick_in;

   always_comb begin
      st_in = st_ff; kick_in = 1'b0; cmd = '0;
      req_ready = (st_ff == S_IDLE);
      rsp_valid = (st_ff == S_OUT);
      case (st_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1; st_in = S_STEPS; kick_in = 1'b1;
         end
         S_STEPS: begin
            cmd.div_op = DIV_STEPS; cmd.div_start = kick_ff;
            if (sts.div_done) begin st_in = S_STEP; kick_in = 1'b1; end
         end
         S_STEP: begin
            cmd.div_op = DIV_STEP; cmd.div_start = kick_ff;
            if (sts.div_done) st_in = S_DECIDE;
         end
         S_DECIDE: begin cmd.decide = 1'b1; st_in = S_FINISH; kick_in = 1'b1; end
         S_FINISH: begin
            // decision result is registered, check it here
            if (sts.need_prog) begin
               cmd.prog_start = 1'b1; st_in = S_PRESC; kick_in = 1'b1;
            end else begin
               cmd.finish = 1'b1; st_in = S_OUT;
            end
         end
         S_PRESC: begin
            cmd.div_op = DIV_PRESC; cmd.div_start = kick_ff;
            if (sts.div_done) begin st_in = S_RELOAD; kick_in = 1'b1; end
         end
         S_RELOAD: begin
            cmd.div_op = DIV_RELOAD;
            cmd.div_start = kick_ff & sts.presc_fit;
            if (kick_ff && !sts.presc_fit) st_in = S_OUT;
            if (sts.div_done) st_in = S_OUT;
            if (st_in == S_OUT) cmd.finish = 1'b1;
         end
         S_OUT: if (rsp_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; kick_ff <= 1'b0;
      end else begin
         st_ff <= st_in; kick_ff <= kick_in;
      end
   end
endmodule

[rtl/core/pwm_frequency_ramp.sv]
// pwm_frequency_ramp: top level, apb registers, controller and datapath
// depends on pfr_pkg, pfr_if, pfr_ctrl, pfr_datapath
//
// channel | dir | transfer
// req     | in  | one update: enable, target, ramp time, tick
// rsp     | out | one result per update
// csr     | in  | apb: timer clock at 0x0, step period at 0x4
//
// the result is offered once the bit-serial divider has run twice, or up to four times when
// the timer is reprogrammed. one update at a time; the next can be taken in the cycle after the
// result transfer. a stalled result holds the block; reset is synchronous and restores the apb
// registers, the controller and the ramp frequency and timer settings, not the request or result.
module pwm_frequency_ramp
   import pfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   pfr_req_if.sink     req,
   pfr_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [31:0] clk_ff;
   logic [9:0] per_ff;
   cmd_type cmd;
   sts_type sts;
   logic wr;

   assign csr_pready = 1'b1;
   assign wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == REG_PERIOD) ? {22'd0, per_ff} : clk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_ff <= CLK_RESET; per_ff <= PERIOD_RESET;
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_paddr[2] == REG_CLK) clk_ff <= csr_pwdata;
         else per_ff <= csr_pwdata[9:0];
      end
   end

   pfr_ctrl u_ctrl (.clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .cmd, .sts);

   pfr_datapath u_dp (.clock, .reset, .cmd, .sts, .req(req.data), .clk_hz(clk_ff),
      .period_ms(per_ff), .result(rsp.data));
endmodule

[rtl/core/pfr_checker.sv]
// pfr_checker: port-level checks for pwm_frequency_ramp, bound to the top level
// depends on pfr_pkg
module pfr_checker
   import pfr_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp dropped");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accepts while result pending");
   a_freq_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pwm_on |-> rsp_data.current_freq == '0)
      else $error("bad stop");
   a_cmp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.compare == 16'((17'(rsp_data.reload) + 17'd1) >> 1))
      else $error("compare mismatch");
   a_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.current_freq != '0 |-> rsp_data.pwm_on)
      else $error("running flag");
endmodule

bind pwm_frequency_ramp pfr_checker u_chk (.clock, .reset, .req_valid(req.valid),
   .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.data));
